[hdl/rip_pkg.sv]
// Shared types and constants of the inventory frame parser.
package rip_pkg;

    localparam int TID_BYTES_DEF = 12;
    localparam int Q_DEPTH       = 4;

    localparam logic [2:0] KIND_EPC     = 3'd0;
    localparam logic [2:0] KIND_TID     = 3'd1;
    localparam logic [2:0] KIND_SUMMARY = 3'd2;
    localparam logic [2:0] KIND_TRUNC   = 3'd3;
    localparam logic [2:0] KIND_BADLEN  = 3'd4;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  byte_value;
        logic [5:0]  byte_index;
        logic [7:0]  antenna_number;
        logic [7:0]  rssi_value;
        logic [31:0] phase_value;
        logic [23:0] freq_value;
        logic [5:0]  epc_length;
        logic        has_tid;
        logic        has_phase_freq;
        logic        last_tag;
        logic        run_last;
    } t_res;

    // one queue entry: the main result of a byte and a truncation marker behind it
    typedef struct packed {
        logic has_main;
        logic trunc;
        t_res res;
    } t_rec;

endpackage

[hdl/rfid_inventory_frame_parser.sv]
// Top level of the UHF inventory response parser.
//
// Input channel: one payload byte per word on i_data_byte, i_frame_end high on
// the final byte. A word is taken when push is high and full is low.
// Result channel: the oldest result word sits on the o_* ports while empty is
// low and is taken when pop is high. A byte makes zero, one or two words;
// o_run_last marks the last word of a byte.
// A byte is taken every cycle while the entry queue has room. Its first word
// passes through the entry queue and the output register before it shows on
// the result ports; a byte with a main and a truncation word shows them in turn.
// The emitter delivers one word per cycle unless the receiver stalls, so the
// four-entry queue between parser and emitter sets how far they drift apart.
// When the receiver stalls, the output register holds its word, the queue
// fills and full rises; bytes without results are still held off then.
// Synchronous reset returns the parser to waiting for a command byte and
// empties the queue and the output register.
module rfid_inventory_frame_parser #(
    parameter int TID_BYTES = rip_pkg::TID_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_frame_end,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_kind,
    output logic [7:0]  o_byte_value,
    output logic [5:0]  o_byte_index,
    output logic [7:0]  o_antenna_number,
    output logic [7:0]  o_rssi_value,
    output logic [31:0] o_phase_value,
    output logic [23:0] o_freq_value,
    output logic [5:0]  o_epc_length,
    output logic        o_has_tid,
    output logic        o_has_phase_freq,
    output logic        o_last_tag,
    output logic        o_run_last
);
    import rip_pkg::*;

    t_rec wr_rec, rd_rec;
    t_res res;
    logic wr_en, q_pop, q_full, q_empty;

    assign full = q_full;

    rip_parser #(
        .TID_BYTES(TID_BYTES)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_q_full    (q_full),
        .i_data_byte (i_data_byte),
        .i_frame_end (i_frame_end),
        .o_wr_en     (wr_en),
        .o_rec       (wr_rec)
    );

    rip_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_data (wr_rec),
        .i_rd_en   (q_pop),
        .o_rd_data (rd_rec),
        .o_full    (q_full),
        .o_empty   (q_empty)
    );

    rip_emitter u_emitter (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rec     (rd_rec),
        .i_q_empty (q_empty),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_res     (res)
    );

    assign o_kind           = res.kind;
    assign o_byte_value     = res.byte_value;
    assign o_byte_index     = res.byte_index;
    assign o_antenna_number = res.antenna_number;
    assign o_rssi_value     = res.rssi_value;
    assign o_phase_value    = res.phase_value;
    assign o_freq_value     = res.freq_value;
    assign o_epc_length     = res.epc_length;
    assign o_has_tid        = res.has_tid;
    assign o_has_phase_freq = res.has_phase_freq;
    assign o_last_tag       = res.last_tag;
    assign o_run_last       = res.run_last;

endmodule

[hdl/rip_parser.sv]
// Front end: byte-wise frame parser that classifies bytes into queue entries.
module rip_parser #(
    parameter int TID_BYTES = rip_pkg::TID_BYTES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic          i_q_full,
    input  logic [7:0]    i_data_byte,
    input  logic          i_frame_end,
    output logic          o_wr_en,
    output rip_pkg::t_rec o_rec
);
    import rip_pkg::*;

    localparam logic [5:0] TID_LEN = 6'(TID_BYTES);

    localparam logic [3:0] ST_CMD    = 4'd0;
    localparam logic [3:0] ST_STATUS = 4'd1;
    localparam logic [3:0] ST_ANT    = 4'd2;
    localparam logic [3:0] ST_COUNT  = 4'd3;
    localparam logic [3:0] ST_OPTION = 4'd4;
    localparam logic [3:0] ST_EPC    = 4'd5;
    localparam logic [3:0] ST_TID    = 4'd6;
    localparam logic [3:0] ST_RSSI   = 4'd7;
    localparam logic [3:0] ST_PHASE  = 4'd8;
    localparam logic [3:0] ST_FREQ   = 4'd9;
    localparam logic [3:0] ST_DONE   = 4'd10;

    logic [3:0]  r_stage, n_stage;
    logic        r_ignored, n_ignored;
    logic [7:0]  r_antenna, n_antenna;
    logic [7:0]  r_blocks, n_blocks;
    logic [5:0]  r_fcnt, n_fcnt;
    logic [5:0]  r_epc_len, n_epc_len;
    logic [1:0]  r_flags, n_flags;
    logic [7:0]  r_rssi, n_rssi;
    logic [31:0] r_phase_val, n_phase_val;
    logic [23:0] r_freq, n_freq;

    logic        accept;
    logic        has_main;
    logic        do_finish;
    logic        trunc;
    logic [2:0]  main_kind;
    logic [5:0]  len;
    logic [5:0]  cnt_inc;
    t_res        main;

    assign accept  = i_push && !i_q_full;
    assign len     = i_data_byte[5:0];
    assign cnt_inc = r_fcnt + 6'd1;

    always_comb begin
        n_stage     = r_stage;
        n_ignored   = r_ignored;
        n_antenna   = r_antenna;
        n_blocks    = r_blocks;
        n_fcnt      = r_fcnt;
        n_epc_len   = r_epc_len;
        n_flags     = r_flags;
        n_rssi      = r_rssi;
        n_phase_val = r_phase_val;
        n_freq      = r_freq;
        has_main    = 1'b0;
        do_finish   = 1'b0;
        main_kind   = KIND_EPC;

        if (!r_ignored) begin
            unique case (r_stage)
                ST_CMD: begin
                    if (i_data_byte == 8'h01) n_stage = ST_STATUS;
                    else n_ignored = 1'b1;
                end
                ST_STATUS: begin
                    if (i_data_byte == 8'h03) n_stage = ST_ANT;
                    else n_ignored = 1'b1;
                end
                ST_ANT: begin
                    n_antenna = i_data_byte;
                    n_stage   = ST_COUNT;
                end
                ST_COUNT: begin
                    n_blocks = i_data_byte;
                    n_stage  = (i_data_byte == 8'd0) ? ST_DONE : ST_OPTION;
                end
                ST_OPTION: begin
                    n_flags     = {i_data_byte[6], i_data_byte[7]};
                    n_phase_val = '0;
                    n_freq      = '0;
                    n_rssi      = '0;
                    n_fcnt      = '0;
                    if (i_data_byte[7] && len < TID_LEN) begin
                        n_epc_len = '0;
                        n_flags   = '0;
                        has_main  = 1'b1;
                        main_kind = KIND_BADLEN;
                        n_ignored = 1'b1;
                    end else begin
                        n_epc_len = i_data_byte[7] ? len - TID_LEN : len;
                        if (n_epc_len != 6'd0) n_stage = ST_EPC;
                        else n_stage = i_data_byte[7] ? ST_TID : ST_RSSI;
                    end
                end
                ST_EPC: begin
                    has_main  = 1'b1;
                    main_kind = KIND_EPC;
                    n_fcnt    = cnt_inc;
                    if (cnt_inc >= r_epc_len) begin
                        n_fcnt  = '0;
                        n_stage = r_flags[0] ? ST_TID : ST_RSSI;
                    end
                end
                ST_TID: begin
                    has_main  = 1'b1;
                    main_kind = KIND_TID;
                    n_fcnt    = cnt_inc;
                    if (cnt_inc >= TID_LEN) begin
                        n_fcnt  = '0;
                        n_stage = ST_RSSI;
                    end
                end
                ST_RSSI: begin
                    n_rssi = i_data_byte;
                    n_fcnt = '0;
                    if (r_flags[1]) n_stage = ST_PHASE;
                    else do_finish = 1'b1;
                end
                ST_PHASE: begin
                    n_phase_val = {r_phase_val[23:0], i_data_byte};
                    n_fcnt      = cnt_inc;
                    if (cnt_inc >= 6'd4) begin
                        n_fcnt  = '0;
                        n_stage = ST_FREQ;
                    end
                end
                ST_FREQ: begin
                    n_freq = {r_freq[15:0], i_data_byte};
                    n_fcnt = cnt_inc;
                    if (cnt_inc >= 6'd3) begin
                        n_fcnt    = '0;
                        do_finish = 1'b1;
                    end
                end
                default: ;
            endcase
        end

        if (do_finish) begin
            has_main  = 1'b1;
            main_kind = KIND_SUMMARY;
            n_blocks  = r_blocks - 8'd1;
            n_stage   = (n_blocks == 8'd0) ? ST_DONE : ST_OPTION;
        end

        main                = '0;
        main.kind           = main_kind;
        main.antenna_number = n_antenna;
        if (main_kind != KIND_BADLEN) begin
            main.epc_length     = n_epc_len;
            main.has_tid        = n_flags[0];
            main.has_phase_freq = n_flags[1];
        end
        if (main_kind == KIND_EPC || main_kind == KIND_TID) begin
            main.byte_value = i_data_byte;
            main.byte_index = r_fcnt;
        end
        if (main_kind == KIND_SUMMARY) begin
            main.rssi_value  = n_rssi;
            main.phase_value = n_phase_val;
            main.freq_value  = n_freq;
            main.last_tag    = (n_blocks == 8'd0);
        end

        // antenna, count or block bytes still expected when the frame closes
        trunc = i_frame_end && !n_ignored && n_stage >= ST_ANT && n_stage <= ST_FREQ;
        if (i_frame_end) begin
            n_stage   = ST_CMD;
            n_ignored = 1'b0;
            n_fcnt    = '0;
        end
    end

    assign o_wr_en      = accept && (has_main || trunc);
    assign o_rec.has_main = has_main;
    assign o_rec.trunc    = trunc;
    assign o_rec.res      = main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage     <= ST_CMD;
            r_ignored   <= 1'b0;
            r_antenna   <= '0;
            r_blocks    <= '0;
            r_fcnt      <= '0;
            r_epc_len   <= '0;
            r_flags     <= '0;
            r_rssi      <= '0;
            r_phase_val <= '0;
            r_freq      <= '0;
        end else if (accept) begin
            r_stage     <= n_stage;
            r_ignored   <= n_ignored;
            r_antenna   <= n_antenna;
            r_blocks    <= n_blocks;
            r_fcnt      <= n_fcnt;
            r_epc_len   <= n_epc_len;
            r_flags     <= n_flags;
            r_rssi      <= n_rssi;
            r_phase_val <= n_phase_val;
            r_freq      <= n_freq;
        end
    end

endmodule

[hdl/rip_queue.sv]
// Short entry queue between the parser and the result emitter.
module rip_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr_en,
    input  rip_pkg::t_rec i_wr_data,
    input  logic          i_rd_en,
    output rip_pkg::t_rec o_rd_data,
    output logic          o_full,
    output logic          o_empty
);
    import rip_pkg::*;

    localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CW = $clog2(Q_DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(Q_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(Q_DEPTH);
    localparam logic [PW-1:0] PTR_ONE  = PW'(1);
    localparam logic [CW-1:0] CNT_ONE  = CW'(1);

    t_rec          r_mem [Q_DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          wr, rd;

    assign o_full    = (r_count == FULL_CNT);
    assign o_empty   = (r_count == '0);
    assign wr        = i_wr_en && !o_full;
    assign rd        = i_rd_en && !o_empty;
    assign o_rd_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wr_ptr] <= i_wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr) r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_ONE;
            if (rd) r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_ONE;
            if (wr && !rd) r_count <= r_count + CNT_ONE;
            else if (rd && !wr) r_count <= r_count - CNT_ONE;
        end
    end

endmodule

[hdl/rip_emitter.sv]
// Back end: expands queue entries into result words behind an output register.
module rip_emitter (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  rip_pkg::t_rec i_rec,
    input  logic          i_q_empty,
    output logic          o_q_pop,
    input  logic          i_pop,
    output logic          o_empty,
    output rip_pkg::t_res o_res
);
    import rip_pkg::*;

    t_res r_out, n_out;
    logic r_valid;
    logic r_sel, n_sel;
    logic load, step;

    assign load    = !r_valid || i_pop;
    assign step    = load && !i_q_empty;
    assign o_empty = !r_valid;
    assign o_res   = r_out;

    always_comb begin
        n_out   = r_out;
        n_sel   = r_sel;
        o_q_pop = 1'b0;
        if (step) begin
            if (!r_sel && i_rec.has_main) begin
                n_out          = i_rec.res;
                n_out.run_last = !i_rec.trunc;
                if (i_rec.trunc) n_sel = 1'b1;
                else o_q_pop = 1'b1;
            end else begin
                // truncation word follows the byte's main word, if any
                n_out                = '0;
                n_out.kind           = KIND_TRUNC;
                n_out.antenna_number = i_rec.res.antenna_number;
                n_out.run_last       = 1'b1;
                n_sel                = 1'b0;
                o_q_pop              = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sel   <= 1'b0;
        end else begin
            if (load) r_valid <= step;
            r_sel <= n_sel;
        end
    end

endmodule

[hdl/rip_checker.sv]
// Port-level checks of the inventory frame parser, bound to the top level.
module rip_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       empty,
    input logic       pop,
    input logic [2:0] o_kind,
    input logic [7:0] o_byte_value,
    input logic [5:0] o_byte_index,
    input logic       o_run_last
);
    import rip_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result channel not empty after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_kind) && $stable(o_byte_value))
        else $error("stalled result word changed");

    a_trunc_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_kind == KIND_TRUNC |-> o_run_last)
        else $error("truncation word not last of its byte");

    a_summary_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_kind == KIND_SUMMARY |-> o_byte_value == 8'd0 && o_byte_index == 6'd0)
        else $error("summary word carries byte fields");

endmodule

bind rfid_inventory_frame_parser rip_checker u_chk (.*);
